// ----- rtl/core/dcp_pkg.sv -----
// dcp_pkg: types, constants and helper functions for the dot-code pattern cell
// used by dcp_dot_calc and dot_code_pattern_cell; no dependencies
package dcp_pkg;

    localparam int unsigned CELL_W   = 12;
    localparam int unsigned PITCH_W  = 8;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned PIX_W    = 20;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 40;
    localparam int unsigned M_USER_W = 2;

    // highest cell coordinate that still draws
    localparam logic [15:0] MAX_CELL = 16'd4095;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 8'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_VALUE      = 2'd0,
        REG_CELL_PITCH      = 2'd1,
        REG_PLAIN_PARITY    = 2'd2,
        REG_HALF_RESOLUTION = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code_value;
        logic [PITCH_W-1:0] cell_pitch;
        logic               plain_parity;
        logic               half_resolution;
    } cfg_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              blank;
    } cell_t;

    typedef struct packed {
        logic             draw;
        logic [PIX_W-1:0] dot_x;
        logic [PIX_W-1:0] dot_y;
        logic             dot_square;
    } dot_t;

    // 2-bit checksum, bit 1 inverted unless plain parity is set
    function automatic logic [1:0] checksum2(input logic [CODE_W-1:0] code,
                                             input logic plain);
        logic hi;
        logic lo;
        hi = code[2] ^ code[8] ^ code[12] ^ code[14];
        lo = code[0] ^ code[4] ^ code[6] ^ code[10];
        return {hi ^ ~plain, lo};
    endfunction

endpackage

// ----- rtl/core/dcp_dot_calc.sv -----
// dcp_dot_calc: maps one grid cell to its dot position and kind
// depends on dcp_pkg
module dcp_dot_calc
    import dcp_pkg::*;
(
    input  cfg_t  cfg,
    input  cell_t grid_cell,
    output dot_t  dot
);

    logic [1:0]       fx;
    logic [1:0]       fy;
    logic [3:0]       slot;
    logic [1:0]       digit;
    logic [PIX_W-1:0] base_x;
    logic [PIX_W-1:0] base_y;
    logic [PIX_W-1:0] off_x;
    logic [PIX_W-1:0] off_y;
    logic             out_of_grid;

    assign fx = grid_cell.cell_x[1:0];
    assign fy = grid_cell.cell_y[1:0];

    assign base_x = PIX_W'(grid_cell.cell_x) * PIX_W'(cfg.cell_pitch);
    assign base_y = PIX_W'(grid_cell.cell_y) * PIX_W'(cfg.cell_pitch);

    // data positions filled row by row from digit 7 down, checksum first
    assign slot = 4'd8 - ({2'b00, fx} - 4'd1) - ({2'b00, fy} - 4'd1) * 4'd3;

    always_comb
    begin
        if (slot == 4'd8)
        begin
            digit = checksum2(cfg.code_value, cfg.plain_parity);
        end
        else
        begin
            digit = cfg.code_value[{slot[2:0], 1'b0} +: 2];
        end
    end

    always_comb
    begin
        off_x = '0;
        off_y = '0;
        if (fx == 2'd0 && fy == 2'd2)
        begin
            // frame marker, one pixel right
            off_x = PIX_W'(1);
        end
        else if (fx != 2'd0 && fy != 2'd0)
        begin
            off_x = (digit == 2'd0 || digit == 2'd3) ? PIX_W'(2) : -PIX_W'(2);
            off_y = (digit == 2'd0 || digit == 2'd1) ? PIX_W'(2) : -PIX_W'(2);
        end
    end

    assign out_of_grid = ({4'b0000, grid_cell.cell_x} > MAX_CELL) ||
                         ({4'b0000, grid_cell.cell_y} > MAX_CELL);

    always_comb
    begin
        if (grid_cell.blank || out_of_grid)
        begin
            dot = '0;
        end
        else
        begin
            dot.draw       = 1'b1;
            dot.dot_x      = base_x + off_x;
            dot.dot_y      = base_y + off_y;
            dot.dot_square = ~cfg.half_resolution;
        end
    end

endmodule

// ----- rtl/core/dot_code_pattern_cell.sv -----
// dot_code_pattern_cell: top level of the dot-code pattern renderer
// depends on dcp_pkg and dcp_dot_calc
//
// usage:
//   s_* channel takes one grid cell per beat: s_tdata holds cell_x and
//   cell_y, s_tuser holds the blank flag.
//   m_* channel gives one dot per cell, in order: m_tdata holds dot_x and
//   dot_y, m_tuser holds draw and dot_square. A cell with no dot gives a
//   beat with draw low and all other fields zero.
//   cfg_we/cfg_index/cfg_wdata write the code, the pitch and the two mode
//   bits; write only while no cell is in flight.
// path: input beat to input register, then result register; one cell per
//   cycle while m_tready is high, with the single multiply-add stage between
//   the two registers.
// reset: both pipeline stages empty, registers at code 0, pitch 12,
//   parity inverted, 2x2 dots.
// stall: when m_tready is low the result register holds its beat and the
//   input register fills; s_tready drops only once both stages are full.
module dot_code_pattern_cell
    import dcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // cell_x[11:0], cell_y[23:12]
    input  logic                  s_tuser,   // blank
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // dot_x[19:0], dot_y[39:20]
    output logic [M_USER_W-1:0]   m_tuser,   // draw[0], dot_square[1]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t  cfg_reg;
    cell_t cell_reg;
    logic  cell_vld_reg;
    dot_t  dot_reg;
    dot_t  dot_next;
    logic  dot_vld_reg;
    logic  out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_value      <= '0;
            cfg_reg.cell_pitch      <= PITCH_RESET;
            cfg_reg.plain_parity    <= 1'b0;
            cfg_reg.half_resolution <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CODE_VALUE:      cfg_reg.code_value      <= cfg_wdata;
                REG_CELL_PITCH:      cfg_reg.cell_pitch      <= cfg_wdata[PITCH_W-1:0];
                REG_PLAIN_PARITY:    cfg_reg.plain_parity    <= cfg_wdata[0];
                REG_HALF_RESOLUTION: cfg_reg.half_resolution <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign out_free = !dot_vld_reg || m_tready;
    assign s_tready = !cell_vld_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            cell_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            cell_reg.cell_x <= s_tdata[CELL_W-1:0];
            cell_reg.cell_y <= s_tdata[2*CELL_W-1:CELL_W];
            cell_reg.blank  <= s_tuser;
        end
    end

    dcp_dot_calc u_calc (
        .cfg       (cfg_reg),
        .grid_cell (cell_reg),
        .dot       (dot_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            dot_vld_reg <= cell_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && cell_vld_reg)
        begin
            dot_reg <= dot_next;
        end
    end

    assign m_tvalid = dot_vld_reg;
    assign m_tdata  = {dot_reg.dot_y, dot_reg.dot_x};
    assign m_tuser  = {dot_reg.dot_square, dot_reg.draw};

endmodule

// ----- rtl/core/dcp_checker.sv -----
// dcp_port_checks: port-level checks on dot_code_pattern_cell, bound to the top level
// depends on dcp_pkg
module dcp_port_checks
    import dcp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [M_USER_W-1:0] m_tuser
);

    // a stalled output beat stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // no dot means an all-zero beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("non-drawing beat carries data");

    // empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a blank cell comes out without a dot once it passes from the input register to a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) ##1 (!m_tvalid || m_tready)
        |=> m_tvalid && !m_tuser[0])
        else $error("blank cell produced a dot or went missing");

endmodule

bind dot_code_pattern_cell dcp_port_checks u_dcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
